@@ rtl/gravity_pair_force_unit_defines.svh @@
// Assertion macros used by the gravity pair force top level.
`ifndef GRAVITY_PAIR_FORCE_UNIT_DEFINES_SVH
`define GRAVITY_PAIR_FORCE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GPF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GPF_ASSERT(lbl, prop, msg)
`define GPF_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/gpf_pkg.sv @@
// Types and constants of the gravity pair force unit.
`default_nettype none
package gpf_pkg;
  localparam int FRAC_BITS      = 16;
  localparam int MIN_DIST_UNITS = 5;
  localparam logic [31:0] G_RESET  = 32'(1) << FRAC_BITS;
  localparam logic [31:0] MD_RESET = 32'(MIN_DIST_UNITS) << FRAC_BITS;

  localparam int MAG_W      = 33;
  localparam int S_W        = 66;
  localparam int P_W        = 96;
  localparam int Q_W        = 95;
  localparam int QDIV_STEPS = 94;
  localparam int SQRT_STEPS = 34;
  localparam int R_W        = 34;
  localparam int T_W        = 127;
  localparam int F_W        = 48;
  localparam int CDIV_STEPS = 48;
  localparam int COMP_LAT   = CDIV_STEPS + 5;

  localparam logic [F_W-1:0] FORCE_MAX = {1'b0, {(F_W-1){1'b1}}};
  localparam logic [F_W-1:0] FORCE_MIN = {1'b1, {(F_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_GRAVITY  = 1'b0,
    CFG_MIN_DIST = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [R_W-1:0]   r;
  } comp_in_t;

  typedef struct packed {
    logic [F_W-1:0] frc;
    logic           sat;
  } comp_out_t;
endpackage
`default_nettype wire

@@ rtl/gpf_comp.sv @@
// One force component: q times gap magnitude, divided by r, then clamped.
`default_nettype none
module gpf_comp (
  input  logic               clk,
  input  logic               en,
  input  gpf_pkg::comp_in_t  din,
  output gpf_pkg::comp_out_t dout
);
  import gpf_pkg::*;

  logic [64:0]    pp0, pp1;
  logic [63:0]    pp2, pp2_b;
  logic [96:0]    tlo;
  logic [T_W-1:0] t3;
  logic [R_W-1:0] r1, r2, r3;
  logic           neg1, neg2, neg3;

  logic [R_W-1:0] dv_rem [0:CDIV_STEPS];
  logic [F_W-1:0] dv_pq  [0:CDIV_STEPS];
  logic [R_W-1:0] dv_r   [0:CDIV_STEPS];
  logic           dv_sat [0:CDIV_STEPS];
  logic           dv_neg [0:CDIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      pp0   <= 65'(din.q[31:0]) * 65'(din.mag);
      pp1   <= 65'(din.q[63:32]) * 65'(din.mag);
      pp2   <= 64'(din.q[94:64]) * 64'(din.mag);
      r1    <= din.r;
      neg1  <= din.neg;
      tlo   <= 97'(pp0) + {pp1, 32'd0};
      pp2_b <= pp2;
      r2    <= r1;
      neg2  <= neg1;
      t3    <= 127'(tlo) + T_W'({pp2_b, 64'd0});
      r3    <= r2;
      neg3  <= neg2;
      dv_sat[0] <= t3 >= T_W'({r3, 48'd0});
      dv_rem[0] <= t3[81:48];
      dv_pq[0]  <= t3[47:0];
      dv_r[0]   <= r3;
      dv_neg[0] <= neg3;
    end
  end

  for (genvar k = 0; k < CDIV_STEPS; k++) begin : g_div
    logic [R_W:0]   rin, diff;
    logic           ge;
    logic [R_W-1:0] rem_next;
    always_comb begin
      rin      = {dv_rem[k], dv_pq[k][F_W-1]};
      diff     = rin - {1'b0, dv_r[k]};
      ge       = rin >= {1'b0, dv_r[k]};
      rem_next = ge ? diff[R_W-1:0] : rin[R_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1] <= rem_next;
        dv_pq[k+1]  <= {dv_pq[k][F_W-2:0], ge};
        dv_r[k+1]   <= dv_r[k];
        dv_sat[k+1] <= dv_sat[k];
        dv_neg[k+1] <= dv_neg[k];
      end
    end
  end

  logic [F_W-1:0] lim, mag;
  logic           over;
  always_comb begin
    lim  = dv_neg[CDIV_STEPS] ? FORCE_MIN : FORCE_MAX;
    over = dv_sat[CDIV_STEPS] || (dv_pq[CDIV_STEPS] > lim);
    mag  = over ? lim : dv_pq[CDIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.frc <= dv_neg[CDIV_STEPS] ? (F_W'(0) - mag) : mag;
      dout.sat <= over;
    end
  end
endmodule
`default_nettype wire

@@ rtl/gravity_pair_force_unit.sv @@
// Top level of the gravity pair force unit.
// Streams body pairs and returns the 2D gravitational force on body 1.
// Input beat (s_tdata): pos1_x, pos1_y, pos2_x, pos2_y, mass1, mass2,
// 32 bits each, lowest first. Output beat: force_x, force_y (48 bits each)
// in m_tdata, too_close and saturated in m_tuser. Body 2 gets the negation.
// Config channel: cfg_index 0 writes gravity_constant, 1 writes min_distance;
// always ready, write only while no pair is in flight.
// Throughput: one pair per cycle while no stall holds the pipeline. An input
// beat reaches m_tvalid through the 94-stage bit-per-stage divider for
// G*m1*m2/s, the 48-stage divider by r and the multiply stages around them.
// Reset: all pipeline valids clear, G returns to 1.0 and min_distance to 5.0.
// Stall: a skid register behind the output register takes one more beat;
// while it is full the whole pipeline holds and s_tready is low.
`default_nettype none
`include "gravity_pair_force_unit_defines.svh"
module gravity_pair_force_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // pos1_x, pos1_y, pos2_x, pos2_y, mass1, mass2
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // force_x, force_y
  output logic [1:0]   m_tuser,  // too_close, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gpf_pkg::*;

  typedef struct packed {
    logic                 tc;
    logic                 capq;
    logic                 nx;
    logic                 ny;
    logic [MAG_W-1:0]     ax;
    logic [MAG_W-1:0]     ay;
    logic [S_W-1:0]       s;
    logic [S_W-1:0]       rem;
    logic [QDIV_STEPS-1:0] pq;
    logic [S_W-1:0]       sr;
    logic [R_W-1:0]       sres;
  } stg_t;

  typedef struct packed {
    logic [F_W-1:0] force_y;
    logic [F_W-1:0] force_x;
    logic           saturated;
    logic           too_close;
  } res_t;

  logic [31:0] gconst, min_dist;
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gconst   <= G_RESET;
      min_dist <= MD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRAVITY:  gconst   <= cfg_data;
        CFG_MIN_DIST: min_dist <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gap vector and magnitudes
  logic [32:0] gx, gy, axn, ayn;
  always_comb begin
    gx  = {s_tdata[31], s_tdata[31:0]} - {s_tdata[95], s_tdata[95:64]};
    gy  = {s_tdata[63], s_tdata[63:32]} - {s_tdata[127], s_tdata[127:96]};
    axn = gx[32] ? (33'd0 - gx) : gx;
    ayn = gy[32] ? (33'd0 - gy) : gy;
  end

  logic             a_v, b_v, c_v;
  logic [MAG_W-1:0] a_ax, a_ay, b_ax, b_ay, c_ax, c_ay;
  logic             a_nx, a_ny, b_nx, b_ny, c_nx, c_ny;
  logic [63:0]      a_gm, b_pl, b_ph, b_md2, c_md2;
  logic [31:0]      a_m2;
  logic [S_W-1:0]   b_sqx, b_sqy, c_s;
  logic [P_W-1:0]   c_p;

  stg_t st   [0:QDIV_STEPS];
  logic st_v [0:QDIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      st_v[0] <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
      b_v <= a_v;
      c_v <= b_v;
      st_v[0] <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax  <= axn;
      a_ay  <= ayn;
      a_nx  <= !gx[32] && (gx != 33'd0);
      a_ny  <= !gy[32] && (gy != 33'd0);
      a_gm  <= 64'(gconst) * 64'(s_tdata[159:128]);
      a_m2  <= s_tdata[191:160];
      b_sqx <= S_W'(a_ax) * S_W'(a_ax);
      b_sqy <= S_W'(a_ay) * S_W'(a_ay);
      b_pl  <= 64'(a_gm[31:0]) * 64'(a_m2);
      b_ph  <= 64'(a_gm[63:32]) * 64'(a_m2);
      b_md2 <= 64'(min_dist) * 64'(min_dist);
      b_ax  <= a_ax;
      b_ay  <= a_ay;
      b_nx  <= a_nx;
      b_ny  <= a_ny;
      c_s   <= b_sqx + b_sqy;
      c_p   <= P_W'(b_pl) + {b_ph, 32'd0};
      c_md2 <= b_md2;
      c_ax  <= b_ax;
      c_ay  <= b_ay;
      c_nx  <= b_nx;
      c_ny  <= b_ny;
      st[0].tc   <= (c_s == '0) || (c_s < S_W'(c_md2));
      st[0].capq <= S_W'(c_p[95:94]) >= c_s;
      st[0].nx   <= c_nx;
      st[0].ny   <= c_ny;
      st[0].ax   <= c_ax;
      st[0].ay   <= c_ay;
      st[0].s    <= c_s;
      st[0].rem  <= S_W'(c_p[95:94]);
      st[0].pq   <= c_p[93:0];
      st[0].sr   <= c_s;
      st[0].sres <= '0;
    end
  end

  // Quotient bit per stage; square root bit per stage in the first stages
  for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_stage
    stg_t            st_next;
    logic [S_W:0]    rin, diff;
    logic            ge;
    if (k < SQRT_STEPS) begin : g_sq
      localparam int B = SQRT_STEPS - 1 - k;
      logic [67:0] term, srw;
      always_comb begin
        st_next = st[k];
        rin     = {st[k].rem, st[k].pq[QDIV_STEPS-1]};
        diff    = rin - {1'b0, st[k].s};
        ge      = rin >= {1'b0, st[k].s};
        st_next.rem = ge ? diff[S_W-1:0] : rin[S_W-1:0];
        st_next.pq  = {st[k].pq[QDIV_STEPS-2:0], ge};
        term = (68'(st[k].sres) << (B + 1)) | (68'(1) << (2 * B));
        srw  = 68'(st[k].sr);
        if (srw >= term) begin
          st_next.sr   = S_W'(srw - term);
          st_next.sres = st[k].sres | (R_W'(1) << B);
        end
      end
    end else begin : g_nsq
      always_comb begin
        st_next = st[k];
        rin     = {st[k].rem, st[k].pq[QDIV_STEPS-1]};
        diff    = rin - {1'b0, st[k].s};
        ge      = rin >= {1'b0, st[k].s};
        st_next.rem = ge ? diff[S_W-1:0] : rin[S_W-1:0];
        st_next.pq  = {st[k].pq[QDIV_STEPS-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else if (en) begin
        st_v[k+1] <= st_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= st_next;
      end
    end
  end

  comp_in_t  cx_in, cy_in;
  comp_out_t cx_out, cy_out;
  logic [Q_W-1:0] qv;

  always_comb begin
    qv = st[QDIV_STEPS].capq ? (Q_W'(1) << QDIV_STEPS) : {1'b0, st[QDIV_STEPS].pq};
    cx_in.q   = qv;
    cx_in.mag = st[QDIV_STEPS].ax;
    cx_in.neg = st[QDIV_STEPS].nx;
    cx_in.r   = st[QDIV_STEPS].sres;
    cy_in.q   = qv;
    cy_in.mag = st[QDIV_STEPS].ay;
    cy_in.neg = st[QDIV_STEPS].ny;
    cy_in.r   = st[QDIV_STEPS].sres;
  end

  gpf_comp u_comp_x (.clk(clk), .en(en), .din(cx_in), .dout(cx_out));
  gpf_comp u_comp_y (.clk(clk), .en(en), .din(cy_in), .dout(cy_out));

  logic dl_v  [0:COMP_LAT-1];
  logic dl_tc [0:COMP_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMP_LAT; i++) dl_v[i] <= 1'b0;
    end else if (en) begin
      dl_v[0] <= st_v[QDIV_STEPS];
      for (int i = 1; i < COMP_LAT; i++) dl_v[i] <= dl_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_tc[0] <= st[QDIV_STEPS].tc;
      for (int i = 1; i < COMP_LAT; i++) dl_tc[i] <= dl_tc[i-1];
    end
  end

  logic fin_v;
  res_t fin_d, out_d, skid_d;
  logic out_v, skid_v;

  always_comb begin
    fin_v = dl_v[COMP_LAT-1];
    fin_d.too_close = dl_tc[COMP_LAT-1];
    fin_d.force_x   = dl_tc[COMP_LAT-1] ? '0 : cx_out.frc;
    fin_d.force_y   = dl_tc[COMP_LAT-1] ? '0 : cy_out.frc;
    fin_d.saturated = !dl_tc[COMP_LAT-1] && (cx_out.sat || cy_out.sat);
  end

  assign en       = !skid_v;
  assign s_tready = en;

  // Output register with skid: park a beat when the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!skid_v) begin
      if (out_v && !m_tready) begin
        if (fin_v) skid_v <= 1'b1;
      end else begin
        out_v <= fin_v;
      end
    end else if (m_tready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      if (out_v && !m_tready) skid_d <= fin_d;
      else out_d <= fin_d;
    end else if (m_tready) begin
      out_d <= skid_d;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_d.force_y, out_d.force_x};
  assign m_tuser  = {out_d.saturated, out_d.too_close};

  `GPF_NEVER(a_skid_alone, skid_v && !out_v, "skid beat held with empty output register")
  `GPF_ASSERT(a_skid_fill, $rose(skid_v) |-> $past(out_v) && $past(!m_tready), "skid filled without stall")
  `GPF_ASSERT(a_close_zero, out_v && out_d.too_close |-> out_d.force_x == '0 && out_d.force_y == '0 && !out_d.saturated, "too close beat carries force")
  `GPF_ASSERT(a_sat_clamp, out_v && out_d.saturated |-> (out_d.force_x == FORCE_MAX) || (out_d.force_x == FORCE_MIN) || (out_d.force_y == FORCE_MAX) || (out_d.force_y == FORCE_MIN), "saturated beat not at a limit")
endmodule
`default_nettype wire

@@ tb/gpf_checker.sv @@
// Checker for the gravity pair force unit: predicts each output beat and compares it.
module gpf_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [191:0]        s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [95:0]         m_tdata,
  input  logic [1:0]          m_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  gpf_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatches,
  output int                  pending
);
  import gpf_pkg::*;

  typedef struct packed {
    logic [47:0] fx;
    logic [47:0] fy;
    logic        too_close;
    logic        sat;
  } force_t;

  logic [31:0] grav_k;
  logic [31:0] min_dist;
  force_t      force_q[$];

  function automatic logic [47:0] force_part(logic [127:0] q, logic signed [33:0] g,
                                             logic [33:0] r, inout logic sat);
    logic [33:0]  mag;
    logic [127:0] t;
    logic [127:0] c;
    logic [47:0]  lim;
    logic         neg;
    mag = g < 0 ? -g : g;
    neg = g > 0;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    t = q * mag;
    c = t / r;
    if (c > lim) begin
      c = lim;
      sat = 1'b1;
    end
    return neg ? -c[47:0] : c[47:0];
  endfunction

  function automatic force_t pair_force(logic [191:0] d);
    logic signed [33:0] gx;
    logic signed [33:0] gy;
    logic [67:0]  s;
    logic [127:0] q;
    logic [33:0]  r;
    logic [33:0]  c;
    logic         sat;
    force_t       f;
    gx = $signed(d[31:0]) - $signed(d[95:64]);
    gy = $signed(d[63:32]) - $signed(d[127:96]);
    s = 68'(gx * gx) + 68'(gy * gy);
    f = '0;
    if (s == 0 || s < 68'(64'(min_dist) * 64'(min_dist))) begin
      f.too_close = 1'b1;
      return f;
    end
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (68'(c) * 68'(c) <= s) r = c;
    end
    q = (128'(grav_k) * 128'(d[159:128]) * 128'(d[191:160])) / 128'(s);
    if (q >= (128'd1 << 94)) q = 128'd1 << 94;
    sat = 1'b0;
    f.fx = force_part(q, gx, r, sat);
    f.fy = force_part(q, gy, r, sat);
    f.sat = sat;
    return f;
  endfunction

  assign pending = force_q.size();

  always_ff @(posedge clk) begin
    force_t e;
    force_t a;
    if (rst) begin
      grav_k     <= G_RESET;
      min_dist   <= MD_RESET;
      mismatches <= 0;
      force_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GRAVITY) grav_k <= cfg_data;
        else min_dist <= cfg_data;
      end
      if (s_tvalid && s_tready) force_q.push_back(pair_force(s_tdata));
      if (m_tvalid && m_tready) begin
        a = {m_tdata[47:0], m_tdata[95:48], m_tuser[0], m_tuser[1]};
        if (force_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected beat %h", a);
        end else begin
          e = force_q.pop_front();
          if (e != a) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("beat mismatch: exp fx %h fy %h tc %b sat %b, got fx %h fy %h tc %b sat %b",
                       e.fx, e.fy, e.too_close, e.sat, a.fx, a.fy, a.too_close, a.sat);
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
// Testbench top for the gravity pair force unit: stimulus, idling and verdict.
module tb_top;
  import gpf_pkg::*;
  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  cfg_index_t   cfg_index;
  logic [31:0]  cfg_data;
  int           mismatches;
  int           pending;
  int           cycles;
  bit           calm;

  gravity_pair_force_unit u_dut (.*);
  gpf_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= calm || $urandom_range(99) >= 20;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(4000)) - 2000) << 16;
      3: return 32'(int'($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  // Hold valid across back-to-back beats; drop it only while idling
  task automatic send_pair(logic [191:0] d);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [191:0] d;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = rand_word($urandom_range(6));
    if ($urandom_range(3) == 0) d[95:64] = d[31:0] + 32'($urandom_range(20) << 14);
    send_pair(d);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (170) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] hi_w [4];
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0; calm = 0; cycles = 0;
    cfg_valid = 0; cfg_index = CFG_GRAVITY; cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    hi_w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    foreach (hi_w[i]) send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, hi_w[i], hi_w[(i+1)%4],
                                 hi_w[(i+2)%4], hi_w[(i+3)%4]});
    send_pair({32'h0001_0000, 32'h0001_0000, 96'h0, 32'h0010_0000});
    send_pair({32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0004_0000});
    send_pair({32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0005_0000});
    send_pair({32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0005_0000, 32'h0});
    send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0000_0100});
    write_reg(CFG_MIN_DIST, 32'h0);
    write_reg(CFG_GRAVITY, 32'hFFFF_FFFF);
    send_pair({32'h0001_0000, 32'h0001_0000, 96'h0, 32'h0000_1234});
    send_pair({64'h0, 128'h0});
    send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0000_0001});
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_reg(CFG_GRAVITY, 32'h0);
        2: begin write_reg(CFG_GRAVITY, $urandom); write_reg(CFG_MIN_DIST, 32'hFFFF_FFFF); end
        3: write_reg(CFG_MIN_DIST, $urandom_range(32'h0010_0000));
        4: begin write_reg(CFG_GRAVITY, 32'h0001_0000); write_reg(CFG_MIN_DIST, 32'h0005_0000); end
        default: ;
      endcase
      calm = (ph == 3);
      for (int i = 0; i < 220; i++) send_random();
      calm = 0;
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/gpf_pkg.sv
rtl/gpf_comp.sv
rtl/gravity_pair_force_unit.sv
tb/gpf_checker.sv
tb/tb_top.sv
